[rtl/isotp_pkg.sv]
// Shared types, constants and helpers of the ISO-TP frame reassembler.
`default_nettype none
package isotp_pkg;

  // Incoming CAN frame.
  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_bytes;
  } frame_t;

  // One result: payload chunk or flow-control frame.
  typedef struct packed {
    logic        result_kind;
    logic [10:0] result_id;
    logic [3:0]  result_count;
    logic [63:0] result_bytes;
    logic        message_end;
    logic        run_last;
  } result_t;

  // Push request from the frame core into the result queue.
  typedef struct packed {
    logic    vld;
    result_t item;
  } push_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSMIT_ID = 1'd1;
  localparam int CFG_DATA_W = 11;

  // Protocol control information types (high nibble of byte 0).
  localparam logic [3:0] PCI_SINGLE = 4'd0;
  localparam logic [3:0] PCI_FIRST  = 4'd1;
  localparam logic [3:0] PCI_CONSEC = 4'd2;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FLOW    = 1'b1;

  localparam logic [7:0]  FC_CTS_PCI   = 8'h30;
  localparam logic [7:0]  FC_STMIN     = 8'h01;
  localparam logic [3:0]  SEQ_MASK     = 4'hF;
  localparam logic [2:0]  SF_LEN_MASK  = 3'h7;
  localparam logic [11:0] FF_BYTES     = 12'd6;
  localparam logic [3:0]  FULL_FRAME   = 4'd8;

  // Exact divide by 7 for values below 4096: (x * 4682) >> 15.
  localparam logic [12:0] DIV7_MUL   = 13'd4682;
  localparam int          DIV7_SHIFT = 15;

  // Result queue depth.
  localparam int OUT_DEPTH = 2;

  // Keep the lowest n bytes of v, zero the rest.
  function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        r[i*8 +: 8] = v[i*8 +: 8];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/isotp_out_fifo.sv]
// Result queue between the frame core and the output channel.
`default_nettype none
module isotp_out_fifo #(
  parameter int DEPTH = isotp_pkg::OUT_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire isotp_pkg::push_t   push,
  output logic                    room,
  output logic                    out_valid,
  input  wire                     out_stall,
  output isotp_pkg::result_t      out_item
);
  import isotp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               wr, rd;

  assign room      = cnt_r != CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_item  = mem[rptr_r];
  assign wr        = push.vld && room;
  assign rd        = out_valid && !out_stall;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (rd) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr_r] <= push.item;
    end
  end

endmodule
`default_nettype wire

[rtl/isotp_frame_core.sv]
// Input register, frame decode, message state and configuration registers.
`default_nettype none
module isotp_frame_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  isotp_pkg::frame_t             in_item,
  input  wire                                 cfg_wr_en,
  input  wire  [isotp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [isotp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                                 room,
  output isotp_pkg::push_t                    push
);
  import isotp_pkg::*;

  frame_t       in_r;
  logic         in_vld_r;
  result_t      pend_r, pend_nxt;
  logic         pend_vld_r, pend_vld_nxt;
  logic [10:0]  rx_id_r, tx_id_r;
  logic [11:0]  mt_r, mt_nxt;
  logic [12:0]  br_r, br_nxt;
  logic [3:0]   seq_r, seq_nxt;

  logic         consume, load;
  logic [7:0]   b0;
  logic [3:0]   ptype;
  logic [3:0]   lenc;
  logic [11:0]  ff_total;
  logic [11:0]  blk_num;
  logic [24:0]  blk_prod;
  logic [7:0]   blk_cnt;
  logic [2:0]   cf_n;
  logic [12:0]  missing;
  logic [3:0]   cf_cnt;
  logic [12:0]  br_sum;
  logic         cf_done;
  result_t      res_a, res_b;
  logic         res_a_vld, res_b_vld;

  assign consume  = in_vld_r && !pend_vld_r && room;
  assign in_stall = in_vld_r && !consume;
  assign load     = in_valid && !in_stall;

  assign b0       = in_r.frame_bytes[7:0];
  assign ptype    = b0[7:4];
  assign lenc     = (in_r.frame_length > FULL_FRAME) ? FULL_FRAME : in_r.frame_length;
  assign ff_total = {b0[3:0] & SEQ_MASK, in_r.frame_bytes[15:8]};
  assign blk_num  = ff_total - FF_BYTES;
  assign blk_prod = blk_num * DIV7_MUL;
  assign blk_cnt  = blk_prod[DIV7_SHIFT +: 8] + 8'd1;
  assign cf_n     = (lenc == '0) ? 3'd0 : 3'(lenc - 4'd1);
  assign missing  = (br_r < {1'b0, mt_r}) ? ({1'b0, mt_r} - br_r) : 13'd0;
  assign cf_cnt   = ({10'd0, cf_n} > missing) ? missing[3:0] : {1'b0, cf_n};
  assign br_sum   = br_r + {9'd0, cf_cnt};
  assign cf_done  = br_sum >= {1'b0, mt_r};

  always_comb begin
    res_a              = '0;
    res_a.result_kind  = KIND_PAYLOAD;
    res_a.result_id    = rx_id_r;
    res_a.run_last     = 1'b1;
    res_a_vld          = 1'b0;
    res_b              = '0;
    res_b.result_kind  = KIND_FLOW;
    res_b.result_id    = tx_id_r;
    res_b.result_count = FULL_FRAME;
    res_b.result_bytes = {40'd0, FC_STMIN, blk_cnt, FC_CTS_PCI};
    res_b.run_last     = 1'b1;
    res_b_vld          = 1'b0;
    mt_nxt             = mt_r;
    br_nxt             = br_r;
    seq_nxt            = seq_r;
    if (in_r.frame_id == rx_id_r) begin
      unique case (ptype)
        PCI_SINGLE: begin
          res_a_vld          = 1'b1;
          res_a.result_count = {1'b0, b0[2:0] & SF_LEN_MASK};
          res_a.result_bytes = keep_bytes({8'd0, in_r.frame_bytes[63:8]},
                                          {1'b0, b0[2:0] & SF_LEN_MASK});
          res_a.message_end  = 1'b1;
        end
        PCI_FIRST: begin
          res_a_vld = 1'b1;
          if (ff_total <= FF_BYTES) begin
            res_a.result_count = ff_total[3:0];
            res_a.result_bytes = keep_bytes({16'd0, in_r.frame_bytes[63:16]}, ff_total[3:0]);
            res_a.message_end  = 1'b1;
            mt_nxt             = '0;
            br_nxt             = '0;
          end else begin
            res_a.result_count = FF_BYTES[3:0];
            res_a.result_bytes = keep_bytes({16'd0, in_r.frame_bytes[63:16]}, FF_BYTES[3:0]);
            res_a.run_last     = 1'b0;
            res_b_vld          = 1'b1;
            mt_nxt             = ff_total;
            br_nxt             = {1'b0, FF_BYTES};
            seq_nxt            = 4'd1;
          end
        end
        PCI_CONSEC: begin
          if (mt_r != '0 && (b0[3:0] & SEQ_MASK) == seq_r) begin
            res_a_vld          = 1'b1;
            res_a.result_count = cf_cnt;
            res_a.result_bytes = keep_bytes({8'd0, in_r.frame_bytes[63:8]}, cf_cnt);
            res_a.message_end  = cf_done;
            seq_nxt            = seq_r + 4'd1;
            if (cf_done) begin
              mt_nxt = '0;
              br_nxt = '0;
            end else begin
              br_nxt = br_sum;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    push         = '0;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    if (pend_vld_r) begin
      push.vld  = 1'b1;
      push.item = pend_r;
      if (room) begin
        pend_vld_nxt = 1'b0;
      end
    end else if (consume) begin
      push.vld  = res_a_vld;
      push.item = res_a;
      if (res_b_vld) begin
        pend_nxt     = res_b;
        pend_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      rx_id_r    <= '0;
      tx_id_r    <= '0;
      mt_r       <= '0;
      br_r       <= '0;
      seq_r      <= '0;
    end else begin
      if (load) begin
        in_vld_r <= 1'b1;
      end else if (consume) begin
        in_vld_r <= 1'b0;
      end
      pend_vld_r <= pend_vld_nxt;
      if (consume) begin
        mt_r  <= mt_nxt;
        br_r  <= br_nxt;
        seq_r <= seq_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_RECEIVE_ID:  rx_id_r <= cfg_wdata;
          REG_TRANSMIT_ID: tx_id_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_r <= in_item;
    end
    pend_r <= pend_nxt;
  end

endmodule
`default_nettype wire

[rtl/isotp_frame_reassembler_unit.sv]
// Top level of the ISO-TP receive-side frame reassembler.
//
//  channel  direction  payload                 handshake
//  in_      input      isotp_pkg::frame_t      in_valid / in_stall
//  out_     output     isotp_pkg::result_t     out_valid / out_stall
//  cfg_     input      index + 11-bit data     cfg_wr_en
//
// A frame is registered, decoded and its result written to the result queue,
// which shows it once written. One frame per cycle unless stalled; a first
// frame with flow control stalls the input while its flow control waits, as
// the queue takes one result a cycle. Reset is synchronous and clears the
// message state, the identifiers and the queue. A full queue stalls the input.
`default_nettype none
module isotp_frame_reassembler_unit #(
  parameter int OUT_DEPTH = isotp_pkg::OUT_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  isotp_pkg::frame_t           in_item,
  output logic                              out_valid,
  input  wire                               out_stall,
  output isotp_pkg::result_t                out_item,
  input  wire                               cfg_wr_en,
  input  wire  [isotp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [isotp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import isotp_pkg::*;

  push_t push;
  logic  room;

  isotp_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .push      (push)
  );

  isotp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[rtl/isotp_frame_reassembler_checker.sv]
// Port-level assertions for the ISO-TP frame reassembler, bound to the top level.
`default_nettype none
module isotp_frame_reassembler_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     out_valid,
  input wire                     out_stall,
  input wire isotp_pkg::result_t out_item
);
  import isotp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_flow_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind == KIND_FLOW |->
      out_item.run_last && !out_item.message_end && out_item.result_count == FULL_FRAME)
    else $error("malformed flow-control result");

  a_flow_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.result_kind == KIND_PAYLOAD && !out_item.run_last
      |=> out_valid && out_item.result_kind == KIND_FLOW)
    else $error("first-frame chunk not followed by flow control");

endmodule

bind isotp_frame_reassembler_unit isotp_frame_reassembler_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
